/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

/* hw/rtl/hsl2rgb_pkg.sv */
// Constants shared by the HSL to RGB converter, its interfaces and its checker.
package hsl2rgb_pkg;

    // Default number of fraction bits; 1.0 is 2**FRAC_BITS.
    localparam int unsigned FRAC_BITS_DEF = 12;

    // Payload widths of the two channels.
    localparam int unsigned HUE_W = 12;
    localparam int unsigned SL_W  = 13;
    localparam int unsigned CH_W  = 8;

    // Colour lanes: red, green, blue.
    localparam int unsigned NUM_CH  = 3;
    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;

    // Hue offset of each lane in sixths of a turn.
    localparam int unsigned CH_OFS [NUM_CH] = '{2, 0, 4};

    // Register stages between an accepted input beat and its output beat.
    localparam int unsigned PIPE_DEPTH = 5;

endpackage

/* hw/rtl/hsl2rgb_if.sv */
// Valid/ready channel interfaces for HSL pixels in and RGB pixels out.
interface hsl2rgb_hsl_if import hsl2rgb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  hue;
    logic [SL_W-1:0]   saturation;
    logic [SL_W-1:0]   lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

interface hsl2rgb_rgb_if import hsl2rgb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* hw/rtl/hsl_to_rgb_converter.sv */
// HSL to RGB converter top level: fully pipelined, five stages, one pixel per clock
// while the output is not stalled.
// Converts one HSL pixel per beat into 8-bit RGB. Hue is a fraction of a
// turn and saturation and lightness are fractions of 1.0, all in fixed point
// with 1.0 = 2**FRAC_BITS (4096 by default); saturation and lightness above
// 1.0 are clamped to 1.0, and hue bits above the fraction are ignored, so a
// hue wraps round the colour circle. Every intermediate value is kept exact
// and each channel is scaled by 255 and truncated, so zero saturation gives
// the gray floor(lightness * 255 / 1.0). The block accepts a new beat on
// every clock while the output is not stalled, and passes each beat
// through five register stages: clamping with the lightness-by-saturation
// product, forming q and p, the three span-by-ramp multipliers, the blend,
// and the scale by 255 into the output register. Each stage holds its own
// valid bit and moves on whenever the stage after it is empty or moving,
// so a stall at the output fills the empty stages before the input side is
// held off, and no beat is lost or repeated. There are no configuration
// registers and no state kept between pixels.
module hsl_to_rgb_converter import hsl2rgb_pkg::*; #(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hsl2rgb_hsl_if.sink      i_pix,
    hsl2rgb_rgb_if.source    o_pix
);

    // Widths that follow from the number of fraction bits.
    localparam int unsigned F     = FRAC_BITS;
    localparam int unsigned LW    = F + 1;                    // clamped s, l and ramp
    localparam int unsigned CLW   = (LW > SL_W) ? LW : SL_W;  // clamp compare
    localparam int unsigned HXW   = (F > HUE_W) ? F : HUE_W;  // hue before masking
    localparam int unsigned XW    = F + 4;                    // hue position below 10.0
    localparam int unsigned QW    = 2 * F + 1;                // q, p and span at 1.0**2
    localparam int unsigned PW    = 3 * F + 1;                // levels at 1.0**3
    localparam int unsigned SW    = PW + 8;                   // level times 255
    localparam int unsigned ONE_I = 1 << F;

    localparam logic [CLW-1:0] ONE_C  = CLW'(ONE_I);
    localparam logic [LW-1:0]  ONE_L  = LW'(ONE_I);
    localparam logic [LW-1:0]  HALF_L = LW'(ONE_I / 2);
    localparam logic [XW-1:0]  ONE_X  = XW'(ONE_I);
    localparam logic [XW-1:0]  THREE_X = XW'(3 * ONE_I);
    localparam logic [XW-1:0]  FOUR_X = XW'(4 * ONE_I);
    localparam logic [XW-1:0]  SIX_X  = XW'(6 * ONE_I);

    // Ramp weight of one hue position: rising, plateau, falling, or none.
    function automatic logic [LW-1:0] ramp_weight(input logic [XW-1:0] x);
        logic [XW-1:0] fall;
        logic [LW-1:0] w;
        fall = FOUR_X - x;
        if (x < ONE_X) begin
            w = x[LW-1:0];
        end else if (x < THREE_X) begin
            w = ONE_L;
        end else if (x < FOUR_X) begin
            w = fall[LW-1:0];
        end else begin
            w = '0;
        end
        return w;
    endfunction

    // Stage enables: a stage loads when it is empty or its successor loads.
    logic en1, en2, en3, en4, en5;

    // Stage 1: clamped inputs, lightness times saturation, ramp weights.
    logic              r_v1;
    logic [LW-1:0]     r_l1, r_s1;
    logic [QW-1:0]     r_ls1;
    logic              r_lo1;
    logic [LW-1:0]     r_t1 [NUM_CH];

    // Stage 2: p and span at scale 1.0**2.
    logic              r_v2;
    logic [QW-1:0]     r_p2, r_span2;
    logic [LW-1:0]     r_t2 [NUM_CH];

    // Stage 3: span times ramp weight per lane.
    logic              r_v3;
    logic [QW-1:0]     r_p3;
    logic [PW-1:0]     r_prod3 [NUM_CH];

    // Stage 4: channel levels at scale 1.0**3.
    logic              r_v4;
    logic [PW-1:0]     r_lvl4 [NUM_CH];

    // Stage 5: output register.
    logic              r_v5;
    logic [CH_W-1:0]   r_ch5 [NUM_CH];

    // Combinational next values.
    logic [CLW-1:0]    n_s_ext, n_l_ext, n_s_c, n_l_c;
    logic [LW-1:0]     n_s1, n_l1;
    logic [HXW-1:0]    n_h_ext;
    logic [F-1:0]      n_h_m;
    logic [XW-1:0]     n_base;
    logic [XW-1:0]     n_x_raw [NUM_CH];
    logic [XW-1:0]     n_x [NUM_CH];
    logic [2*LW-1:0]   n_ls_full;
    logic [QW:0]       n_q_wide, n_p_wide;
    logic [QW-1:0]     n_q2, n_p2;
    logic [PW:0]       n_prod_full [NUM_CH];
    logic [PW:0]       n_lvl_full [NUM_CH];
    logic [SW-1:0]     n_scaled [NUM_CH];

    assign en5 = !r_v5 || o_pix.ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign i_pix.ready = en1;

    // Stage 1 logic: clamp, hue positions per lane wrapped into one turn.
    always_comb begin
        n_s_ext   = CLW'(i_pix.saturation);
        n_l_ext   = CLW'(i_pix.lightness);
        n_s_c     = (n_s_ext > ONE_C) ? ONE_C : n_s_ext;
        n_l_c     = (n_l_ext > ONE_C) ? ONE_C : n_l_ext;
        n_s1      = n_s_c[LW-1:0];
        n_l1      = n_l_c[LW-1:0];
        n_ls_full = n_l1 * n_s1;
        // Six times the hue wraps modulo six turns exactly as the hue wraps
        // modulo one turn, so only the fraction bits are kept.
        n_h_ext   = HXW'(i_pix.hue);
        n_h_m     = n_h_ext[F-1:0];
        n_base    = XW'({n_h_m, 2'b00}) + XW'({n_h_m, 1'b0});
        for (int k = 0; k < NUM_CH; k++) begin
            n_x_raw[k] = n_base + XW'(CH_OFS[k] * ONE_I);
            n_x[k]     = (n_x_raw[k] >= SIX_X) ? n_x_raw[k] - SIX_X : n_x_raw[k];
        end
    end

    // Stage 2 logic: q below half lightness is l*(1+s), else l+s-l*s.
    always_comb begin
        if (r_lo1) begin
            n_q_wide = (QW + 1)'({r_l1, {F{1'b0}}}) + (QW + 1)'(r_ls1);
        end else begin
            n_q_wide = (QW + 1)'({r_l1, {F{1'b0}}}) + (QW + 1)'({r_s1, {F{1'b0}}})
                     - (QW + 1)'(r_ls1);
        end
        n_q2     = n_q_wide[QW-1:0];
        n_p_wide = (QW + 1)'({r_l1, {(F + 1){1'b0}}}) - (QW + 1)'(n_q2);
        n_p2     = n_p_wide[QW-1:0];
    end

    // Stages 3 to 5 logic, one lane per colour.
    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            n_prod_full[k] = r_span2 * r_t2[k];
            n_lvl_full[k]  = (PW + 1)'({r_p3, {F{1'b0}}}) + (PW + 1)'(r_prod3[k]);
            // Times 255 as a shift and a subtraction.
            n_scaled[k]    = {r_lvl4[k], 8'h00} - SW'(r_lvl4[k]);
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_pix.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
            if (en5) begin
                r_v5 <= r_v4;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_l1  <= n_l1;
            r_s1  <= n_s1;
            r_ls1 <= n_ls_full[QW-1:0];
            r_lo1 <= (n_l1 < HALF_L);
            for (int k = 0; k < NUM_CH; k++) begin
                r_t1[k] <= ramp_weight(n_x[k]);
            end
        end
        if (en2) begin
            r_p2    <= n_p2;
            r_span2 <= n_q2 - n_p2;
            for (int k = 0; k < NUM_CH; k++) begin
                r_t2[k] <= r_t1[k];
            end
        end
        if (en3) begin
            r_p3 <= r_p2;
            for (int k = 0; k < NUM_CH; k++) begin
                r_prod3[k] <= n_prod_full[k][PW-1:0];
            end
        end
        if (en4) begin
            for (int k = 0; k < NUM_CH; k++) begin
                r_lvl4[k] <= n_lvl_full[k][PW-1:0];
            end
        end
        if (en5) begin
            for (int k = 0; k < NUM_CH; k++) begin
                r_ch5[k] <= n_scaled[k][3*F+7:3*F];
            end
        end
    end

    assign o_pix.valid = r_v5;
    assign o_pix.red   = r_ch5[CH_RED];
    assign o_pix.green = r_ch5[CH_GREEN];
    assign o_pix.blue  = r_ch5[CH_BLUE];

endmodule

/* hw/rtl/hsl2rgb_chk.sv */
// Port-level checker for the HSL to RGB converter and its bind statement.
`include "assert_macros.svh"

module hsl2rgb_chk import hsl2rgb_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [CH_W-1:0]  i_red,
    input logic [CH_W-1:0]  i_green,
    input logic [CH_W-1:0]  i_blue
);

    localparam int unsigned CNT_W = $clog2(PIPE_DEPTH + 1);

    logic             in_beat, out_beat;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    // Beats accepted but not yet delivered.
    always_comb begin
        n_cnt = r_cnt;
        if (in_beat && !out_beat) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (out_beat && !in_beat) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `ASSERT_CLK_NR(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)
    `ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_red) && $stable(i_green) && $stable(i_blue))
    `ASSERT_CLK(a_no_spurious, i_clk, i_rst_n, i_out_valid |-> r_cnt != '0)
    `ASSERT_CLK(a_depth_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(PIPE_DEPTH))
    `ASSERT_CLK(a_latency, i_clk, i_rst_n, (in_beat && i_out_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> ##1 i_out_valid)

endmodule

bind hsl_to_rgb_converter hsl2rgb_chk u_hsl2rgb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_red       (o_pix.red),
    .i_green     (o_pix.green),
    .i_blue      (o_pix.blue)
);

/* dv/hsl_to_rgb_scoreboard.sv */
// Scoreboard for the HSL to RGB converter: predicts each accepted pixel, checks each RGB beat.
`timescale 1ns / 1ps
module hsl_to_rgb_scoreboard import hsl2rgb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    hsl2rgb_hsl_if  i_hsl,
    hsl2rgb_rgb_if  i_rgb,
    output int      o_fail_count,
    output int      o_pending,
    output int      o_checked
);

    localparam logic [63:0] ONE         = 64'd1 << FRAC_BITS_DEF;
    localparam logic [63:0] TURN        = 64'd6 * ONE;
    localparam int unsigned SCALE_SHIFT = 3 * FRAC_BITS_DEF;
    localparam int          REPORT_MAX  = 10;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_pixel_t;

    rgb_pixel_t expected_rgb_q[$];
    rgb_pixel_t want;
    rgb_pixel_t got;

    // Level of one lane at hue position x, held exactly at scale ONE^3, then scaled by 255.
    function automatic logic [CH_W-1:0] lane_level(logic [63:0] p2, logic [63:0] q2,
                                                   logic [63:0] x);
        logic [63:0] span;
        logic [63:0] level;
        span = q2 - p2;
        if (x < ONE)
            level = p2 * ONE + span * x;
        else if (x < 3 * ONE)
            level = q2 * ONE;
        else if (x < 4 * ONE)
            level = p2 * ONE + span * (4 * ONE - x);
        else
            level = p2 * ONE;
        level = (level * 64'd255) >> SCALE_SHIFT;
        return level[CH_W-1:0];
    endfunction

    function automatic rgb_pixel_t rgb_from_hsl(logic [HUE_W-1:0] hue,
                                                logic [SL_W-1:0] sat,
                                                logic [SL_W-1:0] light);
        logic [63:0] h;
        logic [63:0] s;
        logic [63:0] l;
        logic [63:0] q2;
        logic [63:0] p2;
        logic [63:0] base;
        rgb_pixel_t  px;
        h = 64'(hue);
        s = (64'(sat) > ONE) ? ONE : 64'(sat);
        l = (64'(light) > ONE) ? ONE : 64'(light);
        if (2 * l < ONE)
            q2 = l * (ONE + s);
        else
            q2 = l * ONE + s * ONE - l * s;
        p2   = 2 * l * ONE - q2;
        base = (6 * h) % TURN;
        px.red   = lane_level(p2, q2, (base + CH_OFS[CH_RED] * ONE) % TURN);
        px.green = lane_level(p2, q2, (base + CH_OFS[CH_GREEN] * ONE) % TURN);
        px.blue  = lane_level(p2, q2, (base + CH_OFS[CH_BLUE] * ONE) % TURN);
        return px;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_hsl.valid && i_hsl.ready)
                expected_rgb_q.insert(expected_rgb_q.size(),
                                      rgb_from_hsl(i_hsl.hue, i_hsl.saturation,
                                                   i_hsl.lightness));
            if (i_rgb.valid && i_rgb.ready) begin
                got = '{i_rgb.red, i_rgb.green, i_rgb.blue};
                if (expected_rgb_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_MAX)
                        $display("%0t: RGB beat %02h/%02h/%02h with no pixel outstanding",
                                 $time, got.red, got.green, got.blue);
                end else begin
                    want = expected_rgb_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_MAX)
                            $display("%0t: beat %0d expected %02h/%02h/%02h, got %02h/%02h/%02h",
                                     $time, o_checked, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                    end
                    o_checked++;
                end
            end
            o_pending = expected_rgb_q.size();
        end
    end

endmodule

/* dv/hsl_to_rgb_converter_tb.sv */
// Testbench top for the HSL to RGB converter: clock, reset, pixel stimulus and the verdict.
`timescale 1ns / 1ps
module hsl_to_rgb_converter_tb;
    import hsl2rgb_pkg::*;

    // Number of random pixels in each of the first two pressure phases; the third sends one fewer.
    localparam int PHASE_PIXELS = 667;

    logic i_clk;
    logic i_rst_n;

    hsl2rgb_hsl_if hsl_bus ();
    hsl2rgb_rgb_if rgb_bus ();

    int fail_count;
    int pending_count;
    int checked_count;

    // Percentages of cycles in which the pixel source holds back a beat and
    // the RGB sink refuses one. They are changed between phases.
    int src_gap_pct;
    int snk_stall_pct;

    int directed_count;
    int random_count;

    hsl_to_rgb_converter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (hsl_bus),
        .o_pix   (rgb_bus)
    );

    // The scoreboard watches both channels on its own; the top only drives
    // stimulus and reads back the failure count when the run is over.
    hsl_to_rgb_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hsl        (hsl_bus),
        .i_rgb        (rgb_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // A hard ceiling on the run, far beyond what a correct run needs even if
    // the sink stalled as heavily as it can for the whole run, so only a hang
    // reaches it.
    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

    // The RGB sink decides afresh on every clock whether it will take a beat.
    // With the stall percentage at zero it accepts on every cycle.
    initial begin
        rgb_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rgb_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Offers one pixel and returns just after the edge at which it was taken.
    // Ready is sampled on the falling edge, when it has settled and cannot
    // change before the next rising edge, so the handshake is read without a
    // race against the block's own registers. Each call touches valid at most
    // once per time step: either it lowers it for a gap cycle or it raises it
    // for the new beat.
    task automatic send_pixel(input logic [HUE_W-1:0] hue, input logic [SL_W-1:0] sat,
                              input logic [SL_W-1:0] light);
        logic taken;
        while ($urandom_range(99) < src_gap_pct) begin
            hsl_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        hsl_bus.valid      <= 1'b1;
        hsl_bus.hue        <= hue;
        hsl_bus.saturation <= sat;
        hsl_bus.lightness  <= light;
        do begin
            @(negedge i_clk);
            taken = hsl_bus.ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Values at and around the edges of the legal range and the half-way
    // point of lightness, where the formula for q changes.
    function automatic logic [SL_W-1:0] pick_corner();
        case ($urandom_range(5))
            0:       return SL_W'(0);
            1:       return SL_W'(1);
            2:       return SL_W'(2047);
            3:       return SL_W'(2048);
            4:       return SL_W'(4095);
            default: return SL_W'(4096);
        endcase
    endfunction

    // Most random pixels sit inside the legal range, where the interesting
    // arithmetic is. The rest hit the corners, the gray axis, or carry
    // saturation and lightness above 1.0 so that the clamp and the top bit of
    // both fields are exercised.
    task automatic send_random_pixel();
        int                sel;
        logic [HUE_W-1:0]  hue;
        logic [SL_W-1:0]   sat;
        logic [SL_W-1:0]   light;
        sel = $urandom_range(99);
        hue = HUE_W'($urandom_range(4095));
        if (sel < 65) begin
            sat   = SL_W'($urandom_range(4096));
            light = SL_W'($urandom_range(4096));
        end else if (sel < 80) begin
            sat   = pick_corner();
            light = pick_corner();
        end else if (sel < 90) begin
            sat   = '0;
            light = SL_W'($urandom_range(4096));
        end else begin
            sat   = SL_W'($urandom_range(8191));
            light = SL_W'($urandom_range(8191));
        end
        send_pixel(hue, sat, light);
        random_count++;
    endtask

    initial begin
        // Every input of the block is known from time zero.
        i_rst_n            <= 1'b0;
        hsl_bus.valid      <= 1'b0;
        hsl_bus.hue        <= '0;
        hsl_bus.saturation <= '0;
        hsl_bus.lightness  <= '0;
        src_gap_pct        = 27;
        snk_stall_pct      = 79;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pixels. Black and white, the gray axis (zero saturation,
        // including the lightness just under one half), fully saturated hues
        // on and beside each sixth of the turn, both branches of the q
        // formula, and saturation or lightness above 1.0 which must clamp.
        send_pixel(12'd0,    13'd0,    13'd0);
        send_pixel(12'd4095, 13'd8191, 13'd8191);
        send_pixel(12'd0,    13'd0,    13'd4096);
        send_pixel(12'd2048, 13'd0,    13'd2047);
        send_pixel(12'd777,  13'd0,    13'd1);
        send_pixel(12'd0,    13'd4096, 13'd2048);
        send_pixel(12'd683,  13'd4096, 13'd2048);
        send_pixel(12'd1365, 13'd4096, 13'd2048);
        send_pixel(12'd1366, 13'd4096, 13'd2048);
        send_pixel(12'd2048, 13'd4096, 13'd2048);
        send_pixel(12'd2730, 13'd4096, 13'd2048);
        send_pixel(12'd2731, 13'd4096, 13'd2048);
        send_pixel(12'd3413, 13'd4096, 13'd2048);
        send_pixel(12'd4095, 13'd4096, 13'd2048);
        send_pixel(12'd0,    13'd4096, 13'd2047);
        send_pixel(12'd1000, 13'd4097, 13'd3000);
        send_pixel(12'd3000, 13'd2500, 13'd4097);
        send_pixel(12'd500,  13'd8191, 13'd1024);
        send_pixel(12'd2048, 13'd4096, 13'd4096);
        send_pixel(12'd1234, 13'd4096, 13'd0);
        send_pixel(12'd4095, 13'd1,    13'd1);
        directed_count = 21;

        // Phase one: a mostly willing source against a sink that stalls often,
        // so the pipeline fills up and the input side is held off.
        repeat (PHASE_PIXELS) send_random_pixel();

        // Phase two: a sparse source against a mostly ready sink, so beats
        // travel through a nearly empty pipeline with bubbles on every stage.
        src_gap_pct   = 79;
        snk_stall_pct = 27;
        repeat (PHASE_PIXELS) send_random_pixel();

        // Phase three: full rate in both directions.
        src_gap_pct   = 0;
        snk_stall_pct = 0;
        repeat (PHASE_PIXELS - 1) send_random_pixel();
        hsl_bus.valid <= 1'b0;

        // Drain every outstanding pixel, then let the pipeline run on with its
        // input idle so that any stray output shows.
        do @(negedge i_clk); while (pending_count != 0);
        repeat (4 * PIPE_DEPTH) @(posedge i_clk);
        @(negedge i_clk);

        $display("Run covered %0d directed and %0d random pixels, %0d RGB beats checked,",
                 directed_count, random_count, checked_count);
        $display("across heavy sink stalls, sparse source beats and full-rate streaming.");
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* hsl_to_rgb_converter.f */
+incdir+hw/rtl
hw/rtl/hsl2rgb_pkg.sv
hw/rtl/hsl2rgb_if.sv
hw/rtl/hsl_to_rgb_converter.sv
hw/rtl/hsl2rgb_chk.sv
dv/hsl_to_rgb_scoreboard.sv
dv/hsl_to_rgb_converter_tb.sv
